// ----- hdl/i2cra_pkg.sv -----
// Shared types and constants for the I2C master register access unit.
package i2cra_pkg;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd50;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_DATA  = 2'd3
    } t_command;

    typedef enum logic [4:0] {
        PH_IDLE, PH_FS1, PH_FS2, PH_FS3, PH_ST1, PH_ST2, PH_ST3,
        PH_WBIT_SET, PH_WBIT_CLK, PH_WACK_SET, PH_WACK_CLK,
        PH_RBIT_SET, PH_RBIT_CLK, PH_RACK_SET, PH_RACK_CLK,
        PH_SP1, PH_SP2, PH_SP3, PH_WAIT_DATA
    } t_phase;

    typedef enum logic [1:0] {
        STG_ADDR_W, STG_REG, STG_ADDR_R, STG_DATA
    } t_stage;

    typedef struct packed {
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] length;
        logic [7:0] write_data;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       data_request;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       done_res;
        logic       nack;
    } t_result;

endpackage

// ----- hdl/i2c_master_register_access_unit.sv -----
// Top level: stream input register, bus sequencer, result register, config register.
//
//  channel   | direction | fields (lowest bit first)
//  s_axis    | in        | tuser: command; tdata: dev_addr, reg_addr, length, write_data, sda_in
//  m_axis    | out       | tdata: scl_out, sda_out, busy_res, data_request, read_byte,
//            |           |        read_valid, done_res, nack
//  cfg       | in        | i_cfg_data: phase_ticks
//
// One item per clock while m_axis is not stalled; an item passes the input register, then
// its result is captured in the result register. The sequencer's result is combinational.
// Synchronous active-low reset; phase_ticks resets to 50, pins released.
// A stall on m_axis holds one result; the input register still takes one more item.
module i2c_master_register_access_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // dev_addr, reg_addr, length, write_data, sda_in
    input  logic [1:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // scl_out, sda_out, busy_res, data_request,
                                        // read_byte, read_valid, done_res, nack
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import i2cra_pkg::*;

    logic        r_in_valid;
    logic [39:0] r_in_data;
    logic [1:0]  r_in_user;
    logic        r_out_valid;
    logic [15:0] r_out_data;
    logic [15:0] r_phase_ticks;

    logic        w_advance;
    t_item       w_item;
    t_result     w_res;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign o_cfg_ready   = 1'b1;

    assign w_item.dev_addr   = r_in_data[7:0];
    assign w_item.reg_addr   = r_in_data[15:8];
    assign w_item.length     = r_in_data[23:16];
    assign w_item.write_data = r_in_data[31:24];
    assign w_item.sda_in     = r_in_data[32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase_ticks <= PHASE_TICKS_RESET;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_phase_ticks <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
            r_in_user <= s_axis_tuser;
        end
        if (w_advance) begin
            r_out_data <= {1'b0, w_res.nack, w_res.done_res, w_res.read_valid,
                           w_res.read_byte, w_res.data_request, w_res.busy_res,
                           w_res.sda_out, w_res.scl_out};
        end
    end

    i2cra_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (w_advance),
        .i_command     (t_command'(r_in_user)),
        .i_item        (w_item),
        .i_phase_ticks (r_phase_ticks),
        .o_res         (w_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- hdl/i2cra_seq.sv -----
// Bus sequencer: phase state, delay counter, bit shifter and per-item result.
module i2cra_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  i2cra_pkg::t_command i_command,
    input  i2cra_pkg::t_item   i_item,
    input  logic [15:0]        i_phase_ticks,
    output i2cra_pkg::t_result o_res
);
    import i2cra_pkg::*;

    t_phase     r_phase,       n_phase;
    t_stage     r_stage,       n_stage;
    logic [15:0] r_tick_count, n_tick_count;
    logic [3:0] r_bit_index,   n_bit_index;
    logic [7:0] r_shift_byte,  n_shift_byte;
    logic [7:0] r_bytes_left,  n_bytes_left;
    logic [7:0] r_dev_addr,    n_dev_addr;
    logic [7:0] r_reg_addr,    n_reg_addr;
    logic       r_is_read,     n_is_read;
    logic       r_scl,         n_scl;
    logic       r_sda,         n_sda;
    logic       r_nack_flag,   n_nack_flag;

    logic [15:0] w_tick_inc;
    logic [3:0]  w_bit_inc;
    logic [7:0]  w_wr_shift;
    logic [7:0]  w_rd_shift;
    logic [7:0]  w_bytes_dec;
    logic        w_done;
    logic        w_nack;
    logic        w_rvalid;
    logic [7:0]  w_rbyte;

    assign w_tick_inc  = r_tick_count + 16'd1;
    assign w_bit_inc   = r_bit_index + 4'd1;
    assign w_wr_shift  = {r_shift_byte[6:0], 1'b0};
    assign w_rd_shift  = {r_shift_byte[6:0], i_item.sda_in};
    assign w_bytes_dec = r_bytes_left - 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_stage      <= STG_ADDR_W;
            r_tick_count <= '0;
            r_bit_index  <= '0;
            r_shift_byte <= '0;
            r_bytes_left <= '0;
            r_dev_addr   <= '0;
            r_reg_addr   <= '0;
            r_is_read    <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_nack_flag  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_stage      <= n_stage;
            r_tick_count <= n_tick_count;
            r_bit_index  <= n_bit_index;
            r_shift_byte <= n_shift_byte;
            r_bytes_left <= n_bytes_left;
            r_dev_addr   <= n_dev_addr;
            r_reg_addr   <= n_reg_addr;
            r_is_read    <= n_is_read;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_nack_flag  <= n_nack_flag;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_stage      = r_stage;
        n_tick_count = r_tick_count;
        n_bit_index  = r_bit_index;
        n_shift_byte = r_shift_byte;
        n_bytes_left = r_bytes_left;
        n_dev_addr   = r_dev_addr;
        n_reg_addr   = r_reg_addr;
        n_is_read    = r_is_read;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_nack_flag  = r_nack_flag;
        w_done       = 1'b0;
        w_nack       = 1'b0;
        w_rvalid     = 1'b0;
        w_rbyte      = '0;

        if (i_advance) begin
            if (r_phase == PH_IDLE) begin
                if (i_command == CMD_READ || i_command == CMD_WRITE) begin
                    n_dev_addr   = i_item.dev_addr;
                    n_reg_addr   = i_item.reg_addr;
                    n_bytes_left = i_item.length;
                    n_is_read    = (i_command == CMD_READ);
                    n_stage      = STG_ADDR_W;
                    n_nack_flag  = 1'b0;
                    n_bit_index  = '0;
                    n_shift_byte = '0;
                    n_phase      = PH_FS1;
                    n_sda        = 1'b0;
                    n_tick_count = '0;
                end
            end else if (r_phase == PH_WAIT_DATA) begin
                if (i_command == CMD_DATA) begin
                    n_shift_byte = i_item.write_data;
                    n_bit_index  = '0;
                    n_phase      = PH_WBIT_SET;
                    n_scl        = 1'b0;
                    n_sda        = i_item.write_data[7];
                    n_tick_count = '0;
                end
            end else begin
                n_tick_count = w_tick_inc;
                if (w_tick_inc >= i_phase_ticks) begin
                    n_tick_count = '0;
                    unique case (r_phase)
                        PH_FS1: begin n_phase = PH_FS2; n_scl = 1'b1; end
                        PH_FS2: begin n_phase = PH_FS3; n_sda = 1'b1; end
                        PH_FS3, PH_ST1: begin
                            n_phase = (r_phase == PH_FS3) ? PH_ST1 : PH_ST2;
                            n_scl   = 1'b1;
                            n_sda   = (r_phase == PH_FS3);
                        end
                        PH_ST2: begin n_phase = PH_ST3; n_scl = 1'b0; end
                        PH_ST3: begin
                            n_shift_byte = {r_dev_addr[7:1], r_stage == STG_ADDR_R};
                            n_bit_index  = '0;
                            n_phase      = PH_WBIT_SET;
                            n_scl        = 1'b0;
                            n_sda        = r_dev_addr[7];
                        end
                        PH_WBIT_SET: begin n_phase = PH_WBIT_CLK; n_scl = 1'b1; end
                        PH_WBIT_CLK: begin
                            n_shift_byte = w_wr_shift;
                            n_bit_index  = w_bit_inc;
                            n_scl        = 1'b0;
                            if (w_bit_inc < BITS_PER_BYTE) begin
                                n_phase = PH_WBIT_SET;
                                n_sda   = w_wr_shift[7];
                            end else begin
                                n_phase = PH_WACK_SET;
                                n_sda   = 1'b1;
                            end
                        end
                        PH_WACK_SET: begin n_phase = PH_WACK_CLK; n_scl = 1'b1; end
                        PH_WACK_CLK: begin
                            n_scl = 1'b0;
                            if (r_stage == STG_DATA) begin
                                n_bytes_left = w_bytes_dec;
                                if (w_bytes_dec == 8'd0) begin
                                    n_nack_flag = 1'b0;
                                    n_phase     = PH_SP1;
                                    n_sda       = 1'b0;
                                end else begin
                                    n_phase = PH_WAIT_DATA;
                                end
                            end else if (i_item.sda_in) begin
                                n_nack_flag = 1'b1;
                                n_phase     = PH_SP1;
                                n_sda       = 1'b0;
                            end else if (r_stage == STG_ADDR_W) begin
                                n_stage      = STG_REG;
                                n_shift_byte = r_reg_addr;
                                n_bit_index  = '0;
                                n_phase      = PH_WBIT_SET;
                                n_sda        = r_reg_addr[7];
                            end else if (r_stage == STG_REG) begin
                                if (r_is_read) begin
                                    n_stage = STG_ADDR_R;
                                    n_phase = PH_ST1;
                                    n_scl   = 1'b1;
                                    n_sda   = 1'b1;
                                end else if (r_bytes_left == 8'd0) begin
                                    n_phase = PH_IDLE;
                                    w_done  = 1'b1;
                                end else begin
                                    n_stage = STG_DATA;
                                    n_phase = PH_WAIT_DATA;
                                end
                            end else if (r_bytes_left == 8'd0) begin
                                n_phase = PH_IDLE;
                                w_done  = 1'b1;
                            end else begin
                                n_bit_index  = '0;
                                n_shift_byte = '0;
                                n_phase      = PH_RBIT_SET;
                                n_sda        = 1'b1;
                            end
                        end
                        PH_RBIT_SET: begin n_phase = PH_RBIT_CLK; n_scl = 1'b1; end
                        PH_RBIT_CLK: begin
                            n_shift_byte = w_rd_shift;
                            n_bit_index  = w_bit_inc;
                            n_scl        = 1'b0;
                            if (w_bit_inc < BITS_PER_BYTE) begin
                                n_phase = PH_RBIT_SET;
                                n_sda   = 1'b1;
                            end else begin
                                w_rvalid = 1'b1;
                                w_rbyte  = w_rd_shift;
                                n_phase  = PH_RACK_SET;
                                n_sda    = (r_bytes_left == 8'd1);
                            end
                        end
                        PH_RACK_SET: begin n_phase = PH_RACK_CLK; n_scl = 1'b1; end
                        PH_RACK_CLK: begin
                            n_bytes_left = w_bytes_dec;
                            n_scl        = 1'b0;
                            if (w_bytes_dec == 8'd0) begin
                                n_nack_flag = 1'b0;
                                n_phase     = PH_SP1;
                                n_sda       = 1'b0;
                            end else begin
                                n_bit_index  = '0;
                                n_shift_byte = '0;
                                n_phase      = PH_RBIT_SET;
                                n_sda        = 1'b1;
                            end
                        end
                        PH_SP1: begin n_phase = PH_SP2; n_scl = 1'b1; end
                        PH_SP2: begin n_phase = PH_SP3; n_sda = 1'b1; end
                        PH_SP3: begin
                            n_phase = PH_IDLE;
                            w_done  = 1'b1;
                            w_nack  = r_nack_flag;
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end
            end
        end

        o_res.scl_out      = n_scl;
        o_res.sda_out      = n_sda;
        o_res.busy_res     = (n_phase != PH_IDLE);
        o_res.data_request = (n_phase == PH_WAIT_DATA);
        o_res.read_byte    = w_rbyte;
        o_res.read_valid   = w_rvalid;
        o_res.done_res     = w_done;
        o_res.nack         = w_nack;
    end

    a_nack_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.nack |-> o_res.done_res)
        else $error("nack without done");

    a_read_then_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_res.read_valid) |=> (r_phase == PH_RACK_SET && !r_scl))
        else $error("read byte not followed by ack step");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_phase == PH_IDLE && i_command != CMD_READ
         && i_command != CMD_WRITE) |=> (r_phase == PH_IDLE))
        else $error("left idle without a start command");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_index <= BITS_PER_BYTE)
        else $error("bit index out of range");

endmodule

// ----- tb/tb_i2c_master_register_access_unit.sv -----
// Self-checking testbench for the I2C register access master: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_i2c_master_register_access_unit;

    import i2cra_pkg::*;

    localparam int STALL_LIMIT = 2000;

    localparam t_result RES_NONE     = '0;
    localparam t_result RES_RESET    = t_result'{scl_out: 1'b1, sda_out: 1'b1, default: '0};
    localparam t_result RES_FS1_HIGH = t_result'{scl_out: 1'b1, busy_res: 1'b1, default: '0};
    localparam t_result RES_FS3      = t_result'{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b1,
                                                 default: '0};
    localparam t_result RES_DONE     = t_result'{scl_out: 1'b1, sda_out: 1'b1, done_res: 1'b1,
                                                 default: '0};
    localparam t_result RES_NACK     = t_result'{scl_out: 1'b1, sda_out: 1'b1, done_res: 1'b1,
                                                 nack: 1'b1, default: '0};
    localparam t_result RES_SCL_LOW_DONE = t_result'{sda_out: 1'b1, done_res: 1'b1, default: '0};
    localparam t_result RES_SCL_LOW  = t_result'{sda_out: 1'b1, default: '0};

    typedef struct packed {
        bit          is_cfg;
        logic [15:0] cfg_val;
        t_command    cmd;
        logic [7:0]  dev;
        logic [7:0]  regad;
        logic [7:0]  len;
        logic [7:0]  wdata;
        logic        sda;
        int          reps;
        bit          typed;
        t_result     res;
    } t_step_row;

    // transaction counts follow the bus step sequence at the phase_ticks in force
    localparam t_step_row DIRECTED [34] = '{
        '{0, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0,    1, 1, RES_RESET},
        '{0, 16'd0, CMD_DATA,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,    1, 1, RES_RESET},
        '{0, 16'd0, CMD_WRITE, 8'hA0, 8'h00, 8'h03, 8'h00, 1'b1,    1, 1, RES_FS1_HIGH},
        '{0, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1,   99, 0, RES_NONE},
        '{0, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1,    1, 1, RES_FS3},
        '{1, 16'd1, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0,    1, 0, RES_NONE},
        '{0, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1,   24, 0, RES_NONE},
        '{0, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1,    1, 1, RES_NACK},
        '{1, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0,    1, 0, RES_NONE},
        '{0, 16'd0, CMD_WRITE, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0,    1, 0, RES_NONE},
        '{0, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0,   41, 0, RES_NONE},
        '{0, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0,    1, 1, RES_SCL_LOW_DONE},
        '{0, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0,    1, 1, RES_SCL_LOW},
        '{1, 16'd1, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0,    1, 0, RES_NONE},
        '{0, 16'd0, CMD_READ,  8'h55, 8'h00, 8'hFF, 8'h00, 1'b1,    1, 0, RES_NONE},
        '{0, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1,   23, 0, RES_NONE},
        '{0, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0,    1, 0, RES_NONE},
        '{0, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0,   17, 0, RES_NONE},
        '{0, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1,    1, 0, RES_NONE},
        '{0, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1,    2, 0, RES_NONE},
        '{0, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1,    1, 1, RES_NACK},
        '{0, 16'd0, CMD_WRITE, 8'hFF, 8'h3C, 8'h02, 8'h00, 1'b0,    1, 0, RES_NONE},
        '{0, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0,   42, 0, RES_NONE},
        '{0, 16'd0, CMD_READ,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0,    1, 0, RES_NONE},
        '{0, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0,    3, 0, RES_NONE},
        '{0, 16'd0, CMD_DATA,  8'h00, 8'h00, 8'h00, 8'hA5, 1'b0,    1, 0, RES_NONE},
        '{0, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1,   18, 0, RES_NONE},
        '{0, 16'd0, CMD_DATA,  8'h00, 8'h00, 8'h00, 8'hFF, 1'b1,    1, 0, RES_NONE},
        '{0, 16'd0, CMD_DATA,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1,   20, 0, RES_NONE},
        '{0, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1,    1, 1, RES_DONE},
        '{0, 16'd0, CMD_READ,  8'hFF, 8'hFF, 8'h02, 8'h00, 1'b0,    1, 0, RES_NONE},
        '{0, 16'd0, CMD_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,   63, 0, RES_NONE},
        '{0, 16'd0, CMD_READ,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1,   38, 0, RES_NONE},
        '{0, 16'd0, CMD_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1,    1, 1, RES_DONE}
    };

    localparam logic [15:0] SWEEP_TICKS [5] = '{16'd1, 16'd2, 16'd0, 16'hFFFF, 16'd1};
    localparam int          SWEEP_ITEMS [5] = '{150, 40, 60, 24, 100};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;     // dev_addr, reg_addr, length, write_data, sda_in
    logic [1:0]  s_axis_tuser = '0;     // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // scl_out, sda_out, busy_res, data_request,
                                        // read_byte, read_valid, done_res, nack
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    i2c_master_register_access_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // bus sequencer mirror
    t_phase      ph;
    t_stage      stg;
    logic [15:0] cfg_ticks;
    logic [15:0] tick_cnt;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [7:0]  bytes_to_go;
    logic [7:0]  dev_q;
    logic [7:0]  reg_q;
    logic        rd_q;
    logic        scl_q;
    logic        sda_q;
    logic        stop_nack;
    logic        res_done;
    logic        res_nack;
    logic        res_rv;
    logic [7:0]  res_byte;

    t_result     expected_bus_q[$];
    int          mismatch_count = 0;
    int          stall_cycles = 0;
    bit          calm_run = 1'b0;
    int          sink_hold = 0;
    t_result     got;
    t_result     want;

    task bus_enter(input t_phase p, input logic scl, input logic sda);
        ph       = p;
        scl_q    = scl;
        sda_q    = sda;
        tick_cnt = '0;
    endtask

    task bus_send(input logic [7:0] b);
        shreg   = b;
        bit_cnt = '0;
        bus_enter(PH_WBIT_SET, 1'b0, b[7]);
    endtask

    task bus_finish(input logic nk);
        ph       = PH_IDLE;
        tick_cnt = '0;
        res_done = 1'b1;
        res_nack = nk;
    endtask

    task bus_stop(input logic nk);
        stop_nack = nk;
        bus_enter(PH_SP1, 1'b0, 1'b0);
    endtask

    task bus_expire(input logic smp);
        case (ph)
            PH_FS1: bus_enter(PH_FS2, 1'b1, sda_q);
            PH_FS2: bus_enter(PH_FS3, scl_q, 1'b1);
            PH_FS3: bus_enter(PH_ST1, 1'b1, 1'b1);
            PH_ST1: bus_enter(PH_ST2, scl_q, 1'b0);
            PH_ST2: bus_enter(PH_ST3, 1'b0, sda_q);
            PH_ST3: bus_send({dev_q[7:1], stg == STG_ADDR_R});
            PH_WBIT_SET: bus_enter(PH_WBIT_CLK, 1'b1, sda_q);
            PH_WBIT_CLK: begin
                shreg   = shreg << 1;
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt < BITS_PER_BYTE) bus_enter(PH_WBIT_SET, 1'b0, shreg[7]);
                else bus_enter(PH_WACK_SET, 1'b0, 1'b1);
            end
            PH_WACK_SET: bus_enter(PH_WACK_CLK, 1'b1, sda_q);
            PH_WACK_CLK: begin
                scl_q = 1'b0;
                if (stg == STG_DATA) begin
                    bytes_to_go = bytes_to_go - 8'd1;
                    if (bytes_to_go == 0) bus_stop(1'b0);
                    else bus_enter(PH_WAIT_DATA, 1'b0, sda_q);
                end else if (smp) begin
                    bus_stop(1'b1);
                end else if (stg == STG_ADDR_W) begin
                    stg = STG_REG;
                    bus_send(reg_q);
                end else if (stg == STG_REG) begin
                    if (rd_q) begin
                        stg = STG_ADDR_R;
                        bus_enter(PH_ST1, 1'b1, 1'b1);
                    end else if (bytes_to_go == 0) begin
                        bus_finish(1'b0);
                    end else begin
                        stg = STG_DATA;
                        bus_enter(PH_WAIT_DATA, 1'b0, sda_q);
                    end
                end else if (bytes_to_go == 0) begin
                    bus_finish(1'b0);
                end else begin
                    bit_cnt = '0;
                    shreg   = '0;
                    bus_enter(PH_RBIT_SET, 1'b0, 1'b1);
                end
            end
            PH_RBIT_SET: bus_enter(PH_RBIT_CLK, 1'b1, sda_q);
            PH_RBIT_CLK: begin
                shreg   = {shreg[6:0], smp};
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt < BITS_PER_BYTE) begin
                    bus_enter(PH_RBIT_SET, 1'b0, 1'b1);
                end else begin
                    res_rv   = 1'b1;
                    res_byte = shreg;
                    bus_enter(PH_RACK_SET, 1'b0, bytes_to_go == 8'd1);
                end
            end
            PH_RACK_SET: bus_enter(PH_RACK_CLK, 1'b1, sda_q);
            PH_RACK_CLK: begin
                bytes_to_go = bytes_to_go - 8'd1;
                if (bytes_to_go == 0) begin
                    bus_stop(1'b0);
                end else begin
                    bit_cnt = '0;
                    shreg   = '0;
                    bus_enter(PH_RBIT_SET, 1'b0, 1'b1);
                end
            end
            PH_SP1: bus_enter(PH_SP2, 1'b1, sda_q);
            PH_SP2: bus_enter(PH_SP3, scl_q, 1'b1);
            PH_SP3: bus_finish(stop_nack);
            default: begin
                ph       = PH_IDLE;
                tick_cnt = '0;
            end
        endcase
    endtask

    task predict_bus_result(input t_command cmd, input logic [7:0] dev, input logic [7:0] regad,
                            input logic [7:0] len, input logic [7:0] wdata, input logic smp,
                            output t_result r);
        res_done = 1'b0;
        res_nack = 1'b0;
        res_rv   = 1'b0;
        res_byte = '0;
        if (ph == PH_IDLE) begin
            if (cmd == CMD_READ || cmd == CMD_WRITE) begin
                dev_q       = dev;
                reg_q       = regad;
                bytes_to_go = len;
                rd_q        = (cmd == CMD_READ);
                stg         = STG_ADDR_W;
                stop_nack   = 1'b0;
                bit_cnt     = '0;
                shreg       = '0;
                bus_enter(PH_FS1, scl_q, 1'b0);
            end
        end else if (ph == PH_WAIT_DATA) begin
            if (cmd == CMD_DATA) bus_send(wdata);
        end else begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= cfg_ticks) bus_expire(smp);
        end
        r.scl_out      = scl_q;
        r.sda_out      = sda_q;
        r.busy_res     = (ph != PH_IDLE);
        r.data_request = (ph == PH_WAIT_DATA);
        r.read_byte    = res_rv ? res_byte : 8'h00;
        r.read_valid   = res_rv;
        r.done_res     = res_done;
        r.nack         = res_done && res_nack;
    endtask

    function automatic int next_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_run || roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 2);
        if (roll < 97) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic string fmt_result(input t_result r);
        return $sformatf("scl %b sda %b busy %b dreq %b byte %h rvalid %b done %b nack %b",
                         r.scl_out, r.sda_out, r.busy_res, r.data_request, r.read_byte,
                         r.read_valid, r.done_res, r.nack);
    endfunction

    task drive_item(input t_command cmd, input logic [7:0] dev, input logic [7:0] regad,
                    input logic [7:0] len, input logic [7:0] wdata, input logic smp,
                    input bit typed, input t_result typed_res);
        int      gap;
        t_result r;
        gap = next_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'b0, smp, wdata, len, regad, dev};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_bus_result(cmd, dev, regad, len, wdata, smp, r);
        expected_bus_q.push_back(typed ? typed_res : r);
    endtask

    task wait_results_settled(input int extra);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_bus_q.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task set_phase_ticks(input logic [15:0] v);
        wait_results_settled(4);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_ticks = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task run_traffic(input int budget, input bit allow_start);
        int         count;
        int         roll;
        t_command   cmd;
        logic [7:0] dev;
        logic [7:0] regad;
        logic [7:0] len;
        logic [7:0] wdata;
        logic       smp;
        count = 0;
        while (count < budget || ph != PH_IDLE) begin
            dev   = 8'($urandom_range(0, 255));
            regad = 8'($urandom_range(0, 255));
            len   = 8'($urandom_range(0, 255));
            wdata = 8'($urandom_range(0, 255));
            smp   = 1'($urandom_range(0, 1));
            if (ph == PH_IDLE) begin
                if (allow_start && count < budget && $urandom_range(0, 99) < 80) begin
                    cmd  = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
                    roll = $urandom_range(0, 99);
                    if (roll < 15) len = 8'd0;
                    else if (roll < 70) len = 8'($urandom_range(1, 3));
                    else len = 8'($urandom_range(4, 8));
                    calm_run = ($urandom_range(0, 4) == 0);
                    count++;
                end else begin
                    cmd = $urandom_range(0, 1) ? CMD_TICK : CMD_DATA;
                    if (!allow_start) count++;
                end
            end else begin
                count++;
                if (ph == PH_WAIT_DATA) begin
                    if ($urandom_range(0, 99) < 75) cmd = CMD_DATA;
                    else cmd = t_command'($urandom_range(0, 2));
                end else if ($urandom_range(0, 99) < 90) begin
                    cmd = CMD_TICK;
                end else begin
                    cmd = t_command'($urandom_range(1, 3));
                end
                // mostly acknowledge; a rare NACK aborts address and register bytes
                if (ph == PH_WACK_CLK) smp = ($urandom_range(0, 99) < 4);
            end
            drive_item(cmd, dev, regad, len, wdata, smp, 1'b0, RES_NONE);
        end
    endtask

    always @(negedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (!m_axis_tready) begin
            m_axis_tready <= 1'b1;
            sink_hold     <= $urandom_range(0, 30);
        end else begin
            m_axis_tready <= 1'b0;
            if ($urandom_range(0, 99) < 80) sink_hold <= $urandom_range(0, 2);
            else if ($urandom_range(0, 99) < 85) sink_hold <= $urandom_range(3, 9);
            else sink_hold <= $urandom_range(20, 40);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.scl_out      = m_axis_tdata[0];
            got.sda_out      = m_axis_tdata[1];
            got.busy_res     = m_axis_tdata[2];
            got.data_request = m_axis_tdata[3];
            got.read_byte    = m_axis_tdata[11:4];
            got.read_valid   = m_axis_tdata[12];
            got.done_res     = m_axis_tdata[13];
            got.nack         = m_axis_tdata[14];
            if (expected_bus_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: %s", fmt_result(got));
            end else begin
                want = expected_bus_q.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %s, got %s",
                                 fmt_result(want), fmt_result(got));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("tb_i2c_master_register_access_unit failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        ph          = PH_IDLE;
        stg         = STG_ADDR_W;
        cfg_ticks   = PHASE_TICKS_RESET;
        tick_cnt    = '0;
        bit_cnt     = '0;
        shreg       = '0;
        bytes_to_go = '0;
        dev_q       = '0;
        reg_q       = '0;
        rd_q        = 1'b0;
        scl_q       = 1'b1;
        sda_q       = 1'b1;
        stop_nack   = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].is_cfg) begin
                set_phase_ticks(DIRECTED[i].cfg_val);
            end else begin
                repeat (DIRECTED[i].reps)
                    drive_item(DIRECTED[i].cmd, DIRECTED[i].dev, DIRECTED[i].regad,
                               DIRECTED[i].len, DIRECTED[i].wdata, DIRECTED[i].sda,
                               DIRECTED[i].typed, DIRECTED[i].res);
            end
        end

        foreach (SWEEP_TICKS[k]) begin
            set_phase_ticks(SWEEP_TICKS[k]);
            run_traffic(SWEEP_ITEMS[k], SWEEP_TICKS[k] != 16'hFFFF);
        end

        wait_results_settled(10);
        if (mismatch_count == 0 && expected_bus_q.size() == 0) begin
            $display("tb_i2c_master_register_access_unit passed");
        end else begin
            $display("tb_i2c_master_register_access_unit failed");
        end
        $finish;
    end

endmodule
